>>> src/wva_pkg.sv
package wva_pkg;

  // Default build: 20-entry window of Q8.8 samples
  localparam int WINDOW_DEF       = 20;
  localparam int SAMPLE_WIDTH_DEF = 16;

endpackage

>>> src/wva_div.sv
// Serial signed-by-unsigned divider, one quotient bit per cycle.
// Quotient truncates toward zero; low OUT_W bits returned.
module wva_div #(
  parameter int SUM_W = wva_pkg::SAMPLE_WIDTH_DEF + 5,
  parameter int CNT_W = 5,
  parameter int OUT_W = wva_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    start,
  input  logic signed [SUM_W-1:0] dividend,
  input  logic        [CNT_W-1:0] divisor,
  output logic                    done,
  output logic signed [OUT_W-1:0] quotient
);

  localparam int STEP_W = $clog2(SUM_W + 1);

  logic              running_r;
  logic              done_r;
  logic [STEP_W-1:0] step_r;
  logic [SUM_W-1:0]  quo_r;
  logic [CNT_W-1:0]  rem_r;
  logic [CNT_W-1:0]  div_r;
  logic              neg_r;

  logic [CNT_W:0]    shifted;
  logic [CNT_W:0]    diff;
  logic [SUM_W-1:0]  mag;
  logic [SUM_W-1:0]  signed_quo;

  assign mag     = dividend[SUM_W-1] ? (~dividend + 1'b1) : dividend;
  assign shifted = {rem_r, quo_r[SUM_W-1]};
  assign diff    = shifted - {1'b0, div_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      running_r <= 1'b0;
      done_r    <= 1'b0;
      step_r    <= '0;
    end else begin
      // pulse after the last quotient bit
      done_r <= !start && running_r && (step_r == STEP_W'(1));
      if (start) begin
        running_r <= 1'b1;
        step_r    <= STEP_W'(SUM_W);
      end else if (running_r) begin
        step_r <= step_r - 1'b1;
        if (step_r == STEP_W'(1)) begin
          running_r <= 1'b0;
        end
      end
    end
  end

  // datapath, no reset
  always_ff @(posedge clk) begin
    if (start) begin
      quo_r <= mag;
      rem_r <= '0;
      div_r <= divisor;
      neg_r <= dividend[SUM_W-1];
    end else if (running_r) begin
      if (!diff[CNT_W]) begin
        rem_r <= diff[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b1};
      end else begin
        rem_r <= shifted[CNT_W-1:0];
        quo_r <= {quo_r[SUM_W-2:0], 1'b0};
      end
    end
  end

  assign signed_quo = neg_r ? (~quo_r + 1'b1) : quo_r;
  assign quotient   = signed_quo[OUT_W-1:0];
  assign done       = done_r;

endmodule

>>> src/windowed_velocity_average.sv
// Channel   Direction  Ports
// request   in         in_valid, in_stall, in_linear_sample, in_angular_sample
// result    out        out_valid, out_stall, out_linear_mean, out_angular_mean
//
// A request passes from acceptance through the update, divide and result steps to the
// result register; the divide is done by the serial divider, one quotient bit a cycle.
// The sample store is read in the acceptance cycle and written back in the cycle after.
// Synchronous active-low reset clears slot, fill flag, sums and handshake state;
// the store itself is not cleared: an old entry is subtracted only once the window is full.
// A result held by out_stall waits in the output register; the next request then
// stops before its result step, with in_stall high, until that register frees.
module windowed_velocity_average #(
  parameter int WINDOW       = wva_pkg::WINDOW_DEF,
  parameter int SAMPLE_WIDTH = wva_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_linear_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_angular_sample,
  output logic                           out_valid,
  input  logic                           out_stall,
  output logic signed [SAMPLE_WIDTH-1:0] out_linear_mean,
  output logic signed [SAMPLE_WIDTH-1:0] out_angular_mean
);

  localparam int CNT_W  = $clog2(WINDOW + 1);        // holds 1..WINDOW
  localparam int SUM_W  = SAMPLE_WIDTH + CNT_W;      // WINDOW samples summed
  localparam int SLOT_W = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int EXT_W  = SUM_W - SAMPLE_WIDTH;

  typedef enum logic [1:0] {
    S_IDLE,
    S_UPDATE,
    S_DIVIDE,
    S_RESULT
  } state_t;

  state_t state_r;

  // sample store: both channels side by side in one word
  logic [2*SAMPLE_WIDTH-1:0] store_mem [WINDOW];
  logic [2*SAMPLE_WIDTH-1:0] rd_data_r;

  logic [SLOT_W-1:0]       slot_r;
  logic                    full_r;
  logic signed [SUM_W-1:0] lin_sum_r;
  logic signed [SUM_W-1:0] ang_sum_r;
  logic [SAMPLE_WIDTH-1:0] lin_in_r;
  logic [SAMPLE_WIDTH-1:0] ang_in_r;

  logic                    out_valid_r;
  logic [SAMPLE_WIDTH-1:0] lin_mean_r;
  logic [SAMPLE_WIDTH-1:0] ang_mean_r;

  logic                    in_take;
  logic                    out_free;
  logic [SAMPLE_WIDTH-1:0] lin_old;
  logic [SAMPLE_WIDTH-1:0] ang_old;
  logic signed [SUM_W-1:0] lin_sum_nxt;
  logic signed [SUM_W-1:0] ang_sum_nxt;
  logic [CNT_W-1:0]        count;
  logic                    div_start;
  logic                    lin_done;
  logic                    ang_done;
  logic signed [SAMPLE_WIDTH-1:0] lin_quo;
  logic signed [SAMPLE_WIDTH-1:0] ang_quo;

  assign in_stall = (state_r != S_IDLE);
  assign in_take  = in_valid && !in_stall;
  assign out_free = !out_valid_r || !out_stall;

  assign lin_old = rd_data_r[2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
  assign ang_old = rd_data_r[SAMPLE_WIDTH-1:0];

  // running sums: drop the evicted sample once the window is full, add the new one
  always_comb begin
    lin_sum_nxt = lin_sum_r + {{EXT_W{lin_in_r[SAMPLE_WIDTH-1]}}, lin_in_r};
    ang_sum_nxt = ang_sum_r + {{EXT_W{ang_in_r[SAMPLE_WIDTH-1]}}, ang_in_r};
    if (full_r) begin
      lin_sum_nxt = lin_sum_nxt - {{EXT_W{lin_old[SAMPLE_WIDTH-1]}}, lin_old};
      ang_sum_nxt = ang_sum_nxt - {{EXT_W{ang_old[SAMPLE_WIDTH-1]}}, ang_old};
    end
  end

  // divisor: samples held after this write
  assign count     = full_r ? CNT_W'(WINDOW) : (CNT_W'(slot_r) + 1'b1);
  assign div_start = (state_r == S_UPDATE);

  // store: read the slot about to be overwritten every cycle, write in update
  always_ff @(posedge clk) begin
    rd_data_r <= store_mem[slot_r];
    if (state_r == S_UPDATE) begin
      store_mem[slot_r] <= {lin_in_r, ang_in_r};
    end
  end

  // request capture, no reset
  always_ff @(posedge clk) begin
    if (in_take) begin
      lin_in_r <= in_linear_sample;
      ang_in_r <= in_angular_sample;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      slot_r      <= '0;
      full_r      <= 1'b0;
      lin_sum_r   <= '0;
      ang_sum_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      // the result step reloads the register itself
      if (out_valid_r && !out_stall && state_r != S_RESULT) begin
        out_valid_r <= 1'b0;
      end
      case (state_r)
        S_IDLE: begin
          if (in_take) begin
            state_r <= S_UPDATE;
          end
        end
        S_UPDATE: begin
          lin_sum_r <= lin_sum_nxt;
          ang_sum_r <= ang_sum_nxt;
          if (slot_r == SLOT_W'(WINDOW - 1)) begin
            slot_r <= '0;
            full_r <= 1'b1;
          end else begin
            slot_r <= slot_r + 1'b1;
          end
          state_r <= S_DIVIDE;
        end
        S_DIVIDE: begin
          if (lin_done && ang_done) begin
            state_r <= S_RESULT;
          end
        end
        S_RESULT: begin
          if (out_free) begin
            out_valid_r <= 1'b1;
            lin_mean_r  <= lin_quo;
            ang_mean_r  <= ang_quo;
            state_r     <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

  wva_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .OUT_W (SAMPLE_WIDTH)
  ) u_lin_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (lin_sum_nxt),
    .divisor  (count),
    .done     (lin_done),
    .quotient (lin_quo)
  );

  wva_div #(
    .SUM_W (SUM_W),
    .CNT_W (CNT_W),
    .OUT_W (SAMPLE_WIDTH)
  ) u_ang_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (ang_sum_nxt),
    .divisor  (count),
    .done     (ang_done),
    .quotient (ang_quo)
  );

  assign out_valid        = out_valid_r;
  assign out_linear_mean  = lin_mean_r;
  assign out_angular_mean = ang_mean_r;

endmodule

>>> dv/wva_mean_checker.sv
module wva_mean_checker #(
  parameter int WINDOW       = wva_pkg::WINDOW_DEF,
  parameter int SAMPLE_WIDTH = wva_pkg::SAMPLE_WIDTH_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] in_linear_sample,
  input  logic signed [SAMPLE_WIDTH-1:0] in_angular_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  logic signed [SAMPLE_WIDTH-1:0] out_linear_mean,
  input  logic signed [SAMPLE_WIDTH-1:0] out_angular_mean,
  output int                             mismatches,
  output int                             outstanding,
  output int                             results_checked
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef struct {
    int      req_id;
    sample_t lin;
    sample_t ang;
  } mean_pair_t;

  mean_pair_t expected_means[$];

  // shadow of the block's window
  sample_t lin_hist[WINDOW];
  sample_t ang_hist[WINDOW];
  int      write_ptr;
  bit      filled;
  longint  lin_total;
  longint  ang_total;

  int req_count;
  int fail_tally;
  int result_tally;

  task automatic flag_mismatch(input string msg);
    fail_tally++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  // Drop the oldest sample once full, store the new one, divide by the fill count.
  function automatic mean_pair_t advance_means(input sample_t lin, input sample_t ang);
    mean_pair_t r;
    longint     count;
    if (filled) begin
      lin_total -= lin_hist[write_ptr];
      ang_total -= ang_hist[write_ptr];
    end
    lin_hist[write_ptr] = lin;
    ang_hist[write_ptr] = ang;
    lin_total += lin;
    ang_total += ang;
    write_ptr++;
    count = filled ? WINDOW : write_ptr;
    r.req_id = req_count;
    r.lin    = sample_t'(lin_total / count);
    r.ang    = sample_t'(ang_total / count);
    if (write_ptr >= WINDOW) begin
      filled    = 1'b1;
      write_ptr = 0;
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    mean_pair_t oldest;
    if (!rst_n) begin
      expected_means.delete();
      write_ptr    = 0;
      filled       = 1'b0;
      lin_total    = 0;
      ang_total    = 0;
      req_count    = 0;
      fail_tally   = 0;
      result_tally = 0;
    end else begin
      if (out_valid === 1'b1 && out_stall === 1'b0) begin
        if (expected_means.size() == 0) begin
          flag_mismatch($sformatf("result lin=%0d ang=%0d with no request outstanding",
                                  out_linear_mean, out_angular_mean));
        end else begin
          oldest = expected_means.pop_front();
          result_tally++;
          if (out_linear_mean !== oldest.lin)
            flag_mismatch($sformatf("request %0d linear_mean got %0d want %0d",
                                    oldest.req_id, out_linear_mean, oldest.lin));
          if (out_angular_mean !== oldest.ang)
            flag_mismatch($sformatf("request %0d angular_mean got %0d want %0d",
                                    oldest.req_id, out_angular_mean, oldest.ang));
        end
      end
      if (in_valid === 1'b1 && in_stall === 1'b0) begin
        expected_means.push_back(advance_means(in_linear_sample, in_angular_sample));
        req_count++;
      end
    end
    mismatches      <= fail_tally;
    outstanding     <= expected_means.size();
    results_checked <= result_tally;
  end

endmodule

>>> dv/tb_windowed_velocity_average.sv
module tb_windowed_velocity_average;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int WIN             = wva_pkg::WINDOW_DEF;
  localparam int SW              = wva_pkg::SAMPLE_WIDTH_DEF;
  localparam int RANDOM_REQUESTS = 1800;
  // Slowest legal gap: the serial divide plus random output stall and
  // sender idling; QUIET_LIMIT quiet cycles is far beyond any correct run.
  localparam int QUIET_LIMIT     = 2000;
  localparam int DRAIN_CYCLES    = 40;
  localparam int IDLE_PERCENT    = 33;

  // sample picking modes for the random part
  localparam int MODE_FULL     = 0;
  localparam int MODE_EXTREME  = 1;
  localparam int MODE_SMALL    = 2;
  localparam int MODE_CONSTANT = 3;

  typedef logic signed [SW-1:0] sample_t;

  localparam sample_t S_MAX = {1'b0, {(SW-1){1'b1}}};
  localparam sample_t S_MIN = {1'b1, {(SW-1){1'b0}}};

  logic    clk = 1'b0;
  logic    rst_n = 1'b0;
  logic    in_valid = 1'b0;
  logic    in_stall;
  sample_t in_linear_sample = '0;
  sample_t in_angular_sample = '0;
  logic    out_valid;
  logic    out_stall = 1'b0;
  sample_t out_linear_mean;
  sample_t out_angular_mean;

  int mismatches;
  int outstanding;
  int results_checked;

  bit steady = 1'b0;       // set: neither side idles
  int requests_sent = 0;
  int quiet_cycles = 0;

  always #5 clk = ~clk;

  windowed_velocity_average #(
    .WINDOW      (WIN),
    .SAMPLE_WIDTH(SW)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_linear_sample (in_linear_sample),
    .in_angular_sample(in_angular_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_mean  (out_linear_mean),
    .out_angular_mean (out_angular_mean)
  );

  wva_mean_checker #(
    .WINDOW      (WIN),
    .SAMPLE_WIDTH(SW)
  ) u_mean_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_linear_sample (in_linear_sample),
    .in_angular_sample(in_angular_sample),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_linear_mean  (out_linear_mean),
    .out_angular_mean (out_angular_mean),
    .mismatches       (mismatches),
    .outstanding      (outstanding),
    .results_checked  (results_checked)
  );

  // Result side: stall about a third of cycles, never during the steady stretch.
  always @(posedge clk) begin
    out_stall <= rst_n && !steady && ($urandom_range(99) < IDLE_PERCENT);
  end

  // Watchdog: any cycle with no request or result moving counts towards the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("watchdog: nothing moved for %0d cycles, %0d results outstanding",
               quiet_cycles, outstanding);
      $display("tb_windowed_velocity_average: FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one request; random idle cycles first, then hold until accepted.
  // in_stall is read just after the edge, so it is the value the edge saw.
  task automatic send_request(input sample_t lin, input sample_t ang);
    while (!steady && $urandom_range(99) < IDLE_PERCENT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_linear_sample  <= lin;
    in_angular_sample <= ang;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
  endtask

  // Sender holds off until every outstanding result has come back.
  task automatic wait_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  function automatic sample_t pick_sample(input int mode, input sample_t run_val);
    sample_t v;
    case (mode)
      MODE_EXTREME: begin
        case ($urandom_range(5))
          0:       v = S_MAX;
          1:       v = S_MIN;
          2:       v = '0;
          3:       v = '1;        // -1
          4:       v = sample_t'(1);
          default: v = sample_t'($urandom);
        endcase
      end
      MODE_SMALL:    v = sample_t'($urandom_range(511)) - sample_t'(256);
      MODE_CONSTANT: v = run_val;
      default:       v = sample_t'($urandom);
    endcase
    return v;
  endfunction

  initial begin : stimulus
    int      mode;
    sample_t run_lin;
    sample_t run_ang;
    sample_t d_lin;
    sample_t d_ang;

    mode    = MODE_FULL;
    run_lin = S_MAX;
    run_ang = S_MIN;

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: extremes and sign patterns through the filling phase
    // (divisor = count so far), then a couple past the wrap so the oldest
    // sample starts being subtracted.
    for (int i = 0; i < WIN + 2; i++) begin
      case (i)
        0:       begin d_lin = S_MAX;      d_ang = S_MIN;      end
        1:       begin d_lin = S_MIN;      d_ang = S_MAX;      end
        2:       begin d_lin = '0;         d_ang = '0;         end
        3:       begin d_lin = '1;         d_ang = sample_t'(1); end
        4:       begin d_lin = sample_t'(1); d_ang = '1;       end
        5:       begin d_lin = 16'sh5555;  d_ang = 16'shAAAA;  end
        6:       begin d_lin = 16'shAAAA;  d_ang = 16'sh5555;  end
        default: begin
          if (i < 14) begin
            d_lin = S_MAX;
            d_ang = S_MIN;
          end else begin
            d_lin = S_MIN;
            d_ang = S_MAX;
          end
        end
      endcase
      send_request(d_lin, d_ang);
    end
    wait_drained();

    // Random part: mode changes every 40 requests; constant runs are longer
    // than the window so the sums reach their extremes.
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (n % 40 == 0) begin
        mode    = $urandom_range(MODE_CONSTANT);
        run_lin = $urandom_range(1) ? S_MAX : S_MIN;
        run_ang = $urandom_range(1) ? S_MAX : S_MIN;
      end
      if (n == 600) steady <= 1'b1;
      if (n == 900) begin
        steady <= 1'b0;
        wait_drained();   // mid-run pause with the pipe empty
      end
      send_request(pick_sample(mode, run_lin), pick_sample(mode, run_ang));
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Summary: %0d requests (window fill, wrap, extremes, constant runs), %0d checked",
             requests_sent, results_checked);
    $display("Summary: random stall/idle on both sides, one idle-free stretch, %0d mismatches",
             mismatches);
    if (mismatches == 0 && outstanding == 0)
      $display("tb_windowed_velocity_average: PASS");
    else
      $display("tb_windowed_velocity_average: FAIL");
    $finish;
  end

endmodule
